@@ design/assert_macros.svh @@
// Assertion shorthands used by the elimination order module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME_CYCLE(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error("assertion failed");

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT_CYCLE(label, clk, rst_n, cond, expr) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error("assertion failed");

`endif

@@ design/jeo_pkg.sv @@
// Shared constants and register indexes of the elimination order block.
package jeo_pkg;

    localparam int POS_WIDTH           = 7;
    localparam int CFG_ADDR_WIDTH      = 2;
    localparam int DEFAULT_MAX_ENTRIES = 64;
    localparam int DEFAULT_ENTRY_WIDTH = 32;
    localparam int DEFAULT_STEP_WIDTH  = 16;

    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_START_POSITION = 2'd0;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_STEP_COUNT     = 2'd1;
    localparam logic [CFG_ADDR_WIDTH-1:0] CFG_GROUP_SIZE     = 2'd2;

endpackage

@@ design/josephus_elimination_order.sv @@
// Elimination order engine: loads a circle of words, then emits them in elimination order.
// A word that does not complete the group is stored and busy stays low.
// Each elimination runs a bit-serial remainder of step_count-1 by the live count, walks the
// circle position by position past eliminated words, then eliminates; its word is registered out.
// Busy holds off input for the whole run and drops with the last word; results never stall.
// Reset restores start_position 1, step_count 1, group_size MAX_ENTRIES and an empty load.
`include "assert_macros.svh"

module josephus_elimination_order #(
    parameter int MAX_ENTRIES = jeo_pkg::DEFAULT_MAX_ENTRIES,
    parameter int ENTRY_WIDTH = jeo_pkg::DEFAULT_ENTRY_WIDTH,
    parameter int STEP_WIDTH  = jeo_pkg::DEFAULT_STEP_WIDTH
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              start,
    output logic                              busy,
    input  logic [ENTRY_WIDTH-1:0]            entry_value,
    input  logic                              cfg_write,
    input  logic [jeo_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr,
    input  logic [((STEP_WIDTH > jeo_pkg::POS_WIDTH) ? STEP_WIDTH : jeo_pkg::POS_WIDTH)-1:0]
                                              cfg_data,
    output logic                              result_strobe,
    output logic [ENTRY_WIDTH-1:0]            entry_value_out,
    output logic [jeo_pkg::POS_WIDTH-1:0]     original_position,
    output logic                              last_of_run
);

    localparam int POS_W  = jeo_pkg::POS_WIDTH;
    localparam int ADDR_W = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int LIVE_W = $clog2(MAX_ENTRIES + 1);
    localparam int CNT_W  = $clog2(STEP_WIDTH);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV,
        ST_WALK
    } state_t;

    state_t                  state_reg;
    logic [POS_W-1:0]        start_position_reg;
    logic [STEP_WIDTH-1:0]   step_count_reg;
    logic [POS_W-1:0]        group_size_reg;
    logic [POS_W-1:0]        load_count_reg;
    logic [MAX_ENTRIES-1:0]  eliminated_marks_reg;
    logic [ADDR_W-1:0]       pos_reg;
    logic [LIVE_W-1:0]       live_reg;
    logic [LIVE_W-1:0]       walk_reg;
    logic                    first_reg;
    logic [STEP_WIDTH-1:0]   div_dividend_reg;
    logic [LIVE_W-1:0]       div_rem_reg;
    logic [CNT_W-1:0]        div_cnt_reg;
    logic                    result_strobe_reg;
    logic [POS_W-1:0]        original_position_reg;
    logic                    last_of_run_reg;
    logic [ENTRY_WIDTH-1:0]  read_data_reg;

    logic [ENTRY_WIDTH-1:0]  entry_store [MAX_ENTRIES];

    logic                    accept;
    logic [POS_W-1:0]        slot_pos;
    logic [ADDR_W-1:0]       slot;
    logic [POS_W-1:0]        load_inc;
    logic                    run_start;
    logic [POS_W-1:0]        pos_inc;
    logic [ADDR_W-1:0]       next_pos;
    logic [LIVE_W:0]         div_shift;
    logic [LIVE_W:0]         div_diff;
    logic [LIVE_W-1:0]       div_rem_new;
    logic [LIVE_W-1:0]       live_dec;
    logic                    eliminate;
    logic [POS_W-1:0]        start_first;
    logic [POS_W-1:0]        cfg_pos;
    logic [STEP_WIDTH-1:0]   cfg_step;

    always_comb
    begin
        accept      = start && (state_reg == ST_IDLE);
        slot_pos    = (load_count_reg >= POS_W'(MAX_ENTRIES)) ? '0 : load_count_reg;
        slot        = slot_pos[ADDR_W-1:0];
        load_inc    = slot_pos + POS_W'(1);
        run_start   = accept && (load_inc >= group_size_reg);
        pos_inc     = POS_W'(pos_reg) + POS_W'(1);
        next_pos    = (pos_inc >= group_size_reg) ? '0 : pos_inc[ADDR_W-1:0];
        div_shift   = {div_rem_reg, div_dividend_reg[STEP_WIDTH-1]};
        div_diff    = div_shift - {1'b0, live_reg};
        div_rem_new = (div_shift >= {1'b0, live_reg}) ? div_diff[LIVE_W-1:0]
                                                      : div_shift[LIVE_W-1:0];
        live_dec    = live_reg - LIVE_W'(1);
        eliminate   = (state_reg == ST_WALK) && (walk_reg == '0);
        start_first = start_position_reg - POS_W'(1);
        cfg_pos     = cfg_data[POS_W-1:0];
        cfg_step    = cfg_data[STEP_WIDTH-1:0];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_IDLE;
            start_position_reg    <= POS_W'(1);
            step_count_reg        <= STEP_WIDTH'(1);
            group_size_reg        <= POS_W'(MAX_ENTRIES);
            load_count_reg        <= '0;
            eliminated_marks_reg  <= '0;
            pos_reg               <= '0;
            live_reg              <= '0;
            walk_reg              <= '0;
            first_reg             <= 1'b0;
            div_dividend_reg      <= '0;
            div_rem_reg           <= '0;
            div_cnt_reg           <= '0;
            result_strobe_reg     <= 1'b0;
            original_position_reg <= '0;
            last_of_run_reg       <= 1'b0;
        end
        else
        begin
            result_strobe_reg <= 1'b0;

            unique case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        if (run_start)
                        begin
                            load_count_reg       <= '0;
                            eliminated_marks_reg <= '0;
                            live_reg             <= group_size_reg[LIVE_W-1:0];
                            pos_reg              <= start_first[ADDR_W-1:0];
                            first_reg            <= 1'b1;
                            div_dividend_reg     <= step_count_reg - STEP_WIDTH'(1);
                            div_rem_reg          <= '0;
                            div_cnt_reg          <= '0;
                            state_reg            <= ST_DIV;
                        end
                        else
                        begin
                            load_count_reg <= load_inc;
                        end
                    end
                end
                ST_DIV:
                begin
                    div_dividend_reg <= div_dividend_reg << 1;
                    div_rem_reg      <= div_rem_new;
                    div_cnt_reg      <= div_cnt_reg + CNT_W'(1);
                    if (div_cnt_reg == CNT_W'(STEP_WIDTH - 1))
                    begin
                        walk_reg  <= div_rem_new + (first_reg ? LIVE_W'(0) : LIVE_W'(1));
                        state_reg <= ST_WALK;
                    end
                end
                ST_WALK:
                begin
                    if (eliminate)
                    begin
                        eliminated_marks_reg[pos_reg] <= 1'b1;
                        original_position_reg         <= pos_inc;
                        last_of_run_reg               <= (live_dec == '0);
                        result_strobe_reg             <= 1'b1;
                        live_reg                      <= live_dec;
                        first_reg                     <= 1'b0;
                        div_dividend_reg              <= step_count_reg - STEP_WIDTH'(1);
                        div_rem_reg                   <= '0;
                        div_cnt_reg                   <= '0;
                        state_reg                     <= (live_dec == '0) ? ST_IDLE : ST_DIV;
                    end
                    else
                    begin
                        pos_reg <= next_pos;
                        if (!eliminated_marks_reg[next_pos])
                        begin
                            walk_reg <= walk_reg - LIVE_W'(1);
                        end
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (cfg_write)
            begin
                unique case (cfg_addr)
                    jeo_pkg::CFG_START_POSITION:
                    begin
                        if ((cfg_pos != '0) && (cfg_pos <= group_size_reg))
                        begin
                            start_position_reg <= cfg_pos;
                        end
                    end
                    jeo_pkg::CFG_STEP_COUNT:
                    begin
                        if (cfg_step != '0)
                        begin
                            step_count_reg <= cfg_step;
                        end
                    end
                    jeo_pkg::CFG_GROUP_SIZE:
                    begin
                        if ((cfg_pos != '0) && (cfg_pos <= POS_W'(MAX_ENTRIES))
                            && (start_position_reg <= cfg_pos))
                        begin
                            group_size_reg <= cfg_pos;
                            load_count_reg <= '0;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            entry_store[slot] <= entry_value;
        end
        if (eliminate)
        begin
            read_data_reg <= entry_store[pos_reg];
        end
    end

    assign busy              = (state_reg != ST_IDLE);
    assign result_strobe     = result_strobe_reg;
    assign entry_value_out   = read_data_reg;
    assign original_position = original_position_reg;
    assign last_of_run       = last_of_run_reg;

    `ASSERT_SAME_CYCLE(a_last_word_ends_run, clk, rst_n, result_strobe && last_of_run, !busy)
    `ASSERT_SAME_CYCLE(a_inner_word_keeps_run, clk, rst_n, result_strobe && !last_of_run, busy)
    `ASSERT_NEXT_CYCLE(a_no_word_after_accept, clk, rst_n, start && !busy, !result_strobe)
    `ASSERT_SAME_CYCLE(a_run_has_live_entries, clk, rst_n, busy, live_reg != '0)

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench for the elimination order block, with its own ordering predictor.
module tb_top;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int CFG_DATA_WIDTH =
        (jeo_pkg::DEFAULT_STEP_WIDTH > jeo_pkg::POS_WIDTH) ? jeo_pkg::DEFAULT_STEP_WIDTH
                                                           : jeo_pkg::POS_WIDTH;
    localparam logic [jeo_pkg::CFG_ADDR_WIDTH-1:0] CFG_UNUSED = 2'd3;
    localparam int N_WORDS       = 450;
    localparam int SETTLE_CYCLES = 40;
    localparam int CYCLE_LIMIT   = 1000000;

    typedef logic [jeo_pkg::DEFAULT_ENTRY_WIDTH-1:0] entry_word_t;
    typedef logic [CFG_DATA_WIDTH-1:0] cfg_word_t;

    typedef struct packed {
        entry_word_t                   word;
        logic [jeo_pkg::POS_WIDTH-1:0] pos;
        logic                          last;
    } elim_t;

    typedef enum logic {ROW_REG, ROW_WORD} row_kind_t;

    typedef struct packed {
        row_kind_t                          kind;
        logic [jeo_pkg::CFG_ADDR_WIDTH-1:0] addr;
        cfg_word_t                          data;
        entry_word_t                        word;
        logic                               typed;
        elim_t                              known;
    } stim_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               start = 1'b0;
    logic                               busy;
    entry_word_t                        entry_value = '0;
    logic                               cfg_write = 1'b0;
    logic [jeo_pkg::CFG_ADDR_WIDTH-1:0] cfg_addr = jeo_pkg::CFG_START_POSITION;
    cfg_word_t                          cfg_data = '0;
    logic                               result_strobe;
    entry_word_t                        entry_value_out;
    logic [jeo_pkg::POS_WIDTH-1:0]      original_position;
    logic                               last_of_run;

    entry_word_t circle_words [jeo_pkg::DEFAULT_MAX_ENTRIES];
    logic        out_mark [jeo_pkg::DEFAULT_MAX_ENTRIES];
    int unsigned load_cnt = 0;
    int unsigned cur_start = 1;
    int unsigned cur_step = 1;
    int unsigned cur_size = jeo_pkg::DEFAULT_MAX_ENTRIES;

    elim_t     run_order [$];
    elim_t     pending_eliminations [$];
    stim_row_t directed_rows [$];
    elim_t     want;

    int errors = 0;
    int words_sent = 0;
    int results_seen = 0;
    int runs_seen = 0;
    int cycle_count = 0;

    josephus_elimination_order i_dut (
        .clk              (clk),
        .rst_n            (rst_n),
        .start            (start),
        .busy             (busy),
        .entry_value      (entry_value),
        .cfg_write        (cfg_write),
        .cfg_addr         (cfg_addr),
        .cfg_data         (cfg_data),
        .result_strobe    (result_strobe),
        .entry_value_out  (entry_value_out),
        .original_position(original_position),
        .last_of_run      (last_of_run)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic int idle_pct(input int ph);
        case (ph % 4)
            1:       return 71;
            3:       return 25;
            default: return 0;
        endcase
    endfunction

    function automatic void apply_reg_write(input logic [jeo_pkg::CFG_ADDR_WIDTH-1:0] addr,
                                            input cfg_word_t data);
        int unsigned v7;
        v7 = data[jeo_pkg::POS_WIDTH-1:0];
        case (addr)
            jeo_pkg::CFG_START_POSITION:
                if (v7 >= 1 && v7 <= cur_size)
                    cur_start = v7;
            jeo_pkg::CFG_STEP_COUNT:
                if (data != '0)
                    cur_step = data;
            jeo_pkg::CFG_GROUP_SIZE:
                if (v7 >= 1 && v7 <= jeo_pkg::DEFAULT_MAX_ENTRIES && cur_start <= v7)
                begin
                    cur_size = v7;
                    load_cnt = 0;
                end
            default:
                ;
        endcase
    endfunction

    function automatic int unsigned next_alive(input int unsigned p);
        int unsigned q;
        for (int unsigned i = 1; i <= cur_size; i++)
        begin
            q = (p + i) % cur_size;
            if (!out_mark[q])
                return q;
        end
        return p % cur_size;
    endfunction

    // Stores one word and, when it completes the group, fills run_order with the elimination order.
    function automatic void predict_elimination(input entry_word_t w);
        int unsigned slot;
        int unsigned live;
        int unsigned p;
        int unsigned adv;
        elim_t       r;
        run_order.delete();
        slot = (load_cnt >= jeo_pkg::DEFAULT_MAX_ENTRIES) ? 0 : load_cnt;
        circle_words[slot] = w;
        load_cnt = slot + 1;
        if (load_cnt >= cur_size)
        begin
            load_cnt = 0;
            foreach (out_mark[i])
                out_mark[i] = 1'b0;
            live = cur_size;
            p = (cur_start - 1) % cur_size;
            while (live > 0)
            begin
                adv = (cur_step - 1) % live;
                for (int unsigned i = 0; i < adv; i++)
                    p = next_alive(p);
                out_mark[p] = 1'b1;
                live--;
                r.word = circle_words[p];
                r.pos  = jeo_pkg::POS_WIDTH'(p + 1);
                r.last = (live == 0);
                run_order.push_back(r);
                if (live > 0)
                    p = next_alive(p);
            end
        end
    endfunction

    function automatic void add_reg(input logic [jeo_pkg::CFG_ADDR_WIDTH-1:0] addr,
                                    input cfg_word_t data);
        stim_row_t row;
        row = '0;
        row.kind = ROW_REG;
        row.addr = addr;
        row.data = data;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_word(input entry_word_t w, input logic typed, input elim_t known);
        stim_row_t row;
        row = '0;
        row.kind  = ROW_WORD;
        row.word  = w;
        row.typed = typed;
        row.known = known;
        directed_rows.push_back(row);
    endfunction

    function automatic void check_field(input string name, input entry_word_t expected_val,
                                        input entry_word_t actual_val);
        if (expected_val !== actual_val)
        begin
            errors++;
            $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, name,
                     expected_val, actual_val);
        end
    endfunction

    task automatic wait_quiet();
        start <= 1'b0;
        @(posedge clk);
        while (pending_eliminations.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        while (busy)
            @(posedge clk);
    endtask

    task automatic write_reg(input logic [jeo_pkg::CFG_ADDR_WIDTH-1:0] addr,
                             input cfg_word_t data);
        wait_quiet();
        cfg_write <= 1'b1;
        cfg_addr  <= addr;
        cfg_data  <= data;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        apply_reg_write(addr, data);
    endtask

    task automatic send_word(input entry_word_t w, input int idle_pct, input logic typed,
                             input elim_t known);
        while ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            @(posedge clk);
        end
        start       <= 1'b1;
        entry_value <= w;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        words_sent++;
        predict_elimination(w);
        if (typed)
            pending_eliminations.push_back(known);
        else
            foreach (run_order[i])
                pending_eliminations.push_back(run_order[i]);
    endtask

    always @(posedge clk)
    begin
        if (rst_n && result_strobe)
        begin
            if (pending_eliminations.size() == 0)
            begin
                errors++;
                $display("%0t ns: unexpected word, expected none, got entry %0h position %0d %s %0b",
                         $time, entry_value_out, original_position, "last", last_of_run);
            end
            else
            begin
                want = pending_eliminations.pop_front();
                check_field("entry_value_out", want.word, entry_value_out);
                check_field("original_position", entry_word_t'(want.pos),
                            entry_word_t'(original_position));
                check_field("last_of_run", entry_word_t'(want.last), entry_word_t'(last_of_run));
                results_seen++;
                if (want.last)
                    runs_seen++;
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Timeout after %0d cycles with %0d words still expected", cycle_count,
                     pending_eliminations.size());
            $display("Testbench completed WITH ERRORS");
            $finish;
        end
    end

    initial
    begin
        int        phase;
        int        g;
        int        s;
        int        k;
        int        groups;
        int        pct;
        stim_row_t row;

        add_reg(jeo_pkg::CFG_GROUP_SIZE, 16'd1);
        add_word(32'h0000_0000, 1'b1, {32'h0000_0000, 7'd1, 1'b1});
        add_word(32'hFFFF_FFFF, 1'b1, {32'hFFFF_FFFF, 7'd1, 1'b1});
        // These writes are all rejected, so a one-word group must still come straight back.
        add_reg(jeo_pkg::CFG_START_POSITION, 16'd2);
        add_reg(jeo_pkg::CFG_GROUP_SIZE, 16'd0);
        add_reg(jeo_pkg::CFG_GROUP_SIZE, 16'd65);
        add_reg(CFG_UNUSED, 16'hFFFF);
        add_word(32'hA5C3_0F96, 1'b1, {32'hA5C3_0F96, 7'd1, 1'b1});
        // Bits above the position width are dropped, so this sets a group of two.
        add_reg(jeo_pkg::CFG_GROUP_SIZE, 16'h0102);
        repeat (2) add_word($urandom, 1'b0, '0);
        add_reg(jeo_pkg::CFG_GROUP_SIZE, 16'd5);
        add_reg(jeo_pkg::CFG_START_POSITION, 16'd5);
        add_reg(jeo_pkg::CFG_STEP_COUNT, 16'd2);
        add_reg(jeo_pkg::CFG_STEP_COUNT, 16'd0);
        repeat (5) add_word($urandom, 1'b0, '0);
        // A partial load is thrown away by the group size write that follows.
        repeat (2) add_word($urandom, 1'b0, '0);
        add_reg(jeo_pkg::CFG_START_POSITION, 16'd2);
        add_reg(jeo_pkg::CFG_GROUP_SIZE, 16'd3);
        repeat (3) add_word($urandom, 1'b0, '0);
        add_reg(jeo_pkg::CFG_GROUP_SIZE, 16'd1);
        add_reg(jeo_pkg::CFG_STEP_COUNT, 16'hFFFF);
        add_reg(jeo_pkg::CFG_START_POSITION, 16'd1);
        add_reg(jeo_pkg::CFG_GROUP_SIZE, 16'd7);
        repeat (7) add_word($urandom, 1'b0, '0);

        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            row = directed_rows[i];
            if (row.kind == ROW_REG)
                write_reg(row.addr, row.data);
            else
                send_word(row.word, 0, row.typed, row.known);
        end

        phase = 0;
        while (words_sent < N_WORDS)
        begin
            pct = idle_pct(phase);
            if (phase < 2)
            begin
                g = jeo_pkg::DEFAULT_MAX_ENTRIES;
                s = (phase == 0) ? jeo_pkg::DEFAULT_MAX_ENTRIES : 1;
                k = (phase == 0) ? 65535 : 1;
            end
            else
            begin
                g = (phase == 2) ? 1 : (($urandom_range(9) == 0) ?
                    $urandom_range(jeo_pkg::DEFAULT_MAX_ENTRIES, 1) : $urandom_range(12, 1));
                s = $urandom_range(g, 1);
                case ($urandom_range(2))
                    0:       k = $urandom_range(8, 1);
                    1:       k = $urandom_range(200, 1);
                    default: k = $urandom_range(65535, 1);
                endcase
            end
            if ($urandom_range(3) == 0)
                write_reg(jeo_pkg::CFG_ADDR_WIDTH'($urandom_range(3)),
                          cfg_word_t'($urandom_range(65535)));
            write_reg(jeo_pkg::CFG_START_POSITION, 16'd1);
            write_reg(jeo_pkg::CFG_GROUP_SIZE, cfg_word_t'(g));
            write_reg(jeo_pkg::CFG_START_POSITION, cfg_word_t'(s));
            write_reg(jeo_pkg::CFG_STEP_COUNT, cfg_word_t'(k));
            groups = (g > 16) ? 1 : $urandom_range(4, 1);
            repeat (groups * g) send_word($urandom, pct, 1'b0, '0);
            if (g > 1 && $urandom_range(4) == 0)
                repeat ($urandom_range(g - 1, 1)) send_word($urandom, pct, 1'b0, '0);
            phase++;
        end

        wait_quiet();
        $display("Loaded %0d words over %0d random setting phases after the directed rows.",
                 words_sent, phase);
        $display("Checked %0d eliminated words from %0d complete runs.", results_seen, runs_seen);
        if (errors == 0)
            $display("Testbench completed without errors");
        else
            $display("Testbench completed WITH ERRORS");
        $finish;
    end
endmodule

@@ josephus_elimination_order.f @@
+incdir+design
design/jeo_pkg.sv
design/josephus_elimination_order.sv
tb/tb_top.sv
